FILE: design/fps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Fenwick prefix-sum tree unit.
// No dependencies; the interfaces and the top module refer to it by scoped names.

package fps_pkg;

  // Widths fixed by the request and result formats.
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned DATA_W = 64;
  // Walk position: one bit wider than an index, since the ascending chain can step past it.
  localparam int unsigned POS_W  = IDX_W + 1;

  // Size register value after reset.
  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  // Operation codes carried in the action field; the fourth code is rejected.
  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_PREFIX = 2'd1,
    ACT_RANGE  = 2'd2
  } action_e;

  // Status codes of a response beat.
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_ERROR = 1'b1;

endpackage

FILE: design/fps_req_if.sv
`timescale 1ns / 1ps
// Request channel of the Fenwick prefix-sum tree unit: valid, ready and one request beat.
// Depends on fps_pkg for the field widths.

interface fps_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [fps_pkg::IDX_W-1:0]         index;
  logic [fps_pkg::IDX_W-1:0]         lower_index;
  logic signed [fps_pkg::DATA_W-1:0] delta;

  modport source (output valid, action, index, lower_index, delta, input ready);
  modport sink   (input valid, action, index, lower_index, delta, output ready);
endinterface

FILE: design/fps_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the Fenwick prefix-sum tree unit: valid, ready and one result beat.
// Depends on fps_pkg for the field widths.

interface fps_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [fps_pkg::DATA_W-1:0] sum;
  logic                              status;

  modport source (output valid, sum, status, input ready);
  modport sink   (input valid, sum, status, output ready);
endinterface

FILE: design/fps_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the Fenwick prefix-sum tree unit: the size register.
// Depends on fps_pkg for the data width.

interface fps_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [fps_pkg::IDX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: design/fps_node_ram.sv
`timescale 1ns / 1ps
// Node store of the Fenwick tree: one write port and one read port with registered data.
// No package dependencies; used by fenwick_prefix_sum_tree_unit.

module fps_node_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read and a write to the same address return the old word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/fenwick_prefix_sum_tree_unit.sv
`timescale 1ns / 1ps
// Fenwick prefix-sum tree unit: point update, prefix sum and range sum over signed 64-bit values.
// Depends on fps_pkg, the three channel interfaces and fps_node_ram.
//
// Usage. A request beat on req_i carries an action, an index, a lower index and a delta.
// Every request gives exactly one response beat on rsp_o with a sum and a status bit, unless
// a cfg_i write cuts it short; updates and rejected requests answer with sum zero. cfg_i writes
// the size in use and is always ready; writing it also wipes the tree.
// Timing. One tree node is visited per cycle through a single read port and one shared
// 64-bit adder. The walk visits the nodes of the chain in turn, then the response is registered
// in the final state: an update walks at most 11 nodes, a prefix at most 10 nodes. A range
// sum walks two chains, the second one subtracted. Rejected requests skip the walk and go
// straight to the final state. One request is in flight at a time; req_i.ready is low
// while it is worked on and rises together with the registered response.
// Reset and clearing. After reset, and after every configuration write, a clearing pass
// writes zero to every node, one per cycle; no request is taken meanwhile. The size register
// resets to 1024.
// Stalls. The result sits in an output register; a new request is taken while it waits,
// but that request does not finish until the previous beat has been taken.

module fenwick_prefix_sum_tree_unit #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fps_req_if.sink   req_i,
  fps_rsp_if.source rsp_o,
  fps_cfg_if.sink   cfg_i
);

  localparam int unsigned AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned IDX_W  = fps_pkg::IDX_W;
  localparam int unsigned POS_W  = fps_pkg::POS_W;
  localparam int unsigned DATA_W = fps_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    size_q, size_d;
  logic [AW-1:0]       clr_q, clr_d;
  fps_pkg::action_e    kind_q, kind_d;
  logic                err_q, err_d;
  logic                phase_q, phase_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0]    lom1_q, lom1_d;
  logic [DATA_W-1:0]   delta_q, delta_d;
  logic [DATA_W-1:0]   acc_q, acc_d;
  logic                pend_q, pend_d;
  logic                pend_neg_q, pend_neg_d;
  logic [AW-1:0]       pend_addr_q, pend_addr_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [DATA_W-1:0]   rsp_sum_q, rsp_sum_d;
  logic                rsp_status_q, rsp_status_d;

  logic [IDX_W-1:0]    limit;
  logic [POS_W-1:0]    lowbit;
  logic [POS_W-1:0]    pos_next;
  logic                issue;
  logic [AW-1:0]       raddr;
  logic [DATA_W-1:0]   rdata;
  logic [DATA_W-1:0]   opa, opb;
  logic [DATA_W-1:0]   add_sum;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                req_err;
  logic                is_update;

  // Effective size: the register, saturated at the store depth.
  always_comb begin
    if (32'(size_q) > MAX_ENTRIES) begin
      limit = IDX_W'(MAX_ENTRIES);
    end else begin
      limit = size_q;
    end
  end

  // Reject checks on the incoming request.
  always_comb begin
    unique case (req_i.action)
      fps_pkg::ACT_UPDATE: req_err = (req_i.index == '0) || (req_i.index > limit);
      fps_pkg::ACT_PREFIX: req_err = (req_i.index > limit);
      fps_pkg::ACT_RANGE:  req_err = (req_i.index > limit) || (req_i.lower_index == '0) ||
                                     (req_i.lower_index > limit);
      default:             req_err = 1'b1;
    endcase
  end

  // Chain stepping: updates climb by the lowest set bit, queries descend by it.
  assign is_update = (kind_q == fps_pkg::ACT_UPDATE);
  assign lowbit    = pos_q & (~pos_q + POS_W'(1));
  always_comb begin
    if (is_update) begin
      issue    = (pos_q != '0) && (pos_q <= {1'b0, limit});
      pos_next = pos_q + lowbit;
    end else begin
      issue    = (pos_q != '0);
      pos_next = pos_q - lowbit;
    end
  end
  assign raddr = AW'(pos_q - POS_W'(1));

  // Shared adder: node plus delta for updates, accumulator plus or minus node for queries.
  assign opa     = is_update ? delta_q : acc_q;
  assign opb     = pend_neg_q ? ~rdata : rdata;
  assign add_sum = opa + opb + DATA_W'(pend_neg_q);

  // Store write port: zeros during the clearing pass, else the update write-back.
  assign ram_we    = (state_q == S_CLEAR) || (pend_q && is_update);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : pend_addr_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : add_sum;

  fps_node_ram #(
    .DEPTH  (MAX_ENTRIES),
    .WIDTH  (DATA_W),
    .ADDR_W (AW)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    ((state_q == S_WALK) && issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    clr_d        = clr_q;
    kind_d       = kind_q;
    err_d        = err_q;
    phase_d      = phase_q;
    pos_d        = pos_q;
    lom1_d       = lom1_q;
    delta_d      = delta_q;
    acc_d        = acc_q;
    pend_d       = 1'b0;
    pend_neg_d   = pend_neg_q;
    pend_addr_d  = pend_addr_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_sum_d    = rsp_sum_q;
    rsp_status_d = rsp_status_q;

    // A node read issued last cycle is folded in now.
    if (pend_q && !is_update) begin
      acc_d = add_sum;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          err_d   = req_err;
          kind_d  = req_err ? fps_pkg::ACT_PREFIX : fps_pkg::action_e'(req_i.action);
          pos_d   = {1'b0, req_i.index};
          lom1_d  = req_i.lower_index - IDX_W'(1);
          delta_d = req_i.delta;
          acc_d   = '0;
          phase_d = 1'b0;
          state_d = req_err ? S_FIN : S_WALK;
        end
      end
      S_WALK: begin
        if (issue) begin
          pend_d      = 1'b1;
          pend_neg_d  = phase_q;
          pend_addr_d = raddr;
          pos_d       = pos_next;
        end else if ((kind_q == fps_pkg::ACT_RANGE) && !phase_q) begin
          // Second chain of a range sum, subtracted.
          phase_d = 1'b1;
          pos_d   = {1'b0, lom1_q};
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_sum_d    = err_q ? '0 : acc_q;
          rsp_status_d = err_q ? fps_pkg::ST_ERROR : fps_pkg::ST_DONE;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase

    // A size write restarts the clearing pass.
    if (cfg_i.valid) begin
      size_d  = cfg_i.data;
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      size_q      <= fps_pkg::SIZE_RESET;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      kind_q      <= fps_pkg::ACT_PREFIX;
      err_q       <= 1'b0;
      phase_q     <= 1'b0;
      pend_neg_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
      kind_q      <= kind_d;
      err_q       <= err_d;
      phase_q     <= phase_d;
      pend_neg_q  <= pend_neg_d;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    lom1_q       <= lom1_d;
    delta_q      <= delta_d;
    acc_q        <= acc_d;
    pend_addr_q  <= pend_addr_d;
    rsp_sum_q    <= rsp_sum_d;
    rsp_status_q <= rsp_status_d;
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.sum    = rsp_sum_q;
  assign rsp_o.status = rsp_status_q;

  // An accepted request keeps the request side closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && !cfg_i.valid |=> !req_i.ready)
    else $error("request side open right after a request beat");

  // The store is written back only by updates or by the clearing pass.
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR) || (is_update && $past(state_q) == S_WALK))
    else $error("node store written outside an update or clearing pass");

  // Rejected requests answer with a zero sum.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == fps_pkg::ST_ERROR) |-> (rsp_o.sum == '0))
    else $error("error response with nonzero sum");

endmodule
